### hw/rtl/pss_pkg.sv
// Shared types, character codes and helpers for the printf spec parser.
package pss_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned FlagW  = 5;
  localparam int unsigned LenW   = 6;
  localparam int unsigned NumW   = 16;
  localparam logic [NumW-1:0] NumMax = '1;

  localparam logic [CharW-1:0] CH_NUL   = 8'h00;
  localparam logic [CharW-1:0] CH_MINUS = 8'h2d;
  localparam logic [CharW-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CharW-1:0] CH_SPACE = 8'h20;
  localparam logic [CharW-1:0] CH_SHARP = 8'h23;
  localparam logic [CharW-1:0] CH_DOT   = 8'h2e;
  localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CH_NINE  = 8'h39;
  localparam logic [CharW-1:0] CH_Z     = 8'h7a;
  localparam logic [CharW-1:0] CH_J     = 8'h6a;
  localparam logic [CharW-1:0] CH_L     = 8'h6c;
  localparam logic [CharW-1:0] CH_H     = 8'h68;

  // flag bit positions
  localparam int unsigned F_MINUS = 0;
  localparam int unsigned F_PLUS  = 1;
  localparam int unsigned F_SPACE = 2;
  localparam int unsigned F_SHARP = 3;
  localparam int unsigned F_ZERO  = 4;

  // length modifier bit positions
  localparam int unsigned L_H  = 0;
  localparam int unsigned L_HH = 1;
  localparam int unsigned L_L  = 2;
  localparam int unsigned L_LL = 3;
  localparam int unsigned L_J  = 4;
  localparam int unsigned L_Z  = 5;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_L    = 2'd1,
    PEND_H    = 2'd2
  } pend_e;

  typedef struct packed {
    logic [FlagW-1:0] flags;
    logic [LenW-1:0]  length;
    logic [NumW-1:0]  width;
    logic             dot;
    logic [NumW-1:0]  prec;
    logic             in_prec;
    logic             in_width;
    pend_e            pending;
  } pss_state_t;

  typedef struct packed {
    logic [CharW-1:0] conv_type;
    logic [FlagW-1:0] flag_bits;
    logic [LenW-1:0]  length_bits;
    logic [NumW-1:0]  field_width;
    logic             has_precision;
    logic [NumW-1:0]  precision;
  } pss_rec_t;

  typedef struct packed {
    logic       emit;
    pss_state_t nxt;
    pss_rec_t   rec;
  } pss_step_t;

  // acc * 10 + digit, saturated to the 16-bit range
  function automatic logic [NumW-1:0] add_digit(logic [NumW-1:0] acc, logic [3:0] d);
    logic [NumW+3:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{NumW{1'b0}}, d};
    return (v[NumW+3:NumW] != '0) ? NumMax : v[NumW-1:0];
  endfunction

endpackage

### hw/rtl/pss_if.sv
// Valid/ready channels: format characters in, conversion records out.
interface pss_ch_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface pss_spec_if;
  logic        valid;
  logic        ready;
  logic [7:0]  conv_type;
  logic [4:0]  flag_bits;
  logic [5:0]  length_bits;
  logic [15:0] field_width;
  logic        has_precision;
  logic [15:0] precision;

  modport source (output valid, output conv_type, output flag_bits, output length_bits,
                  output field_width, output has_precision, output precision,
                  input ready);
  modport sink   (input valid, input conv_type, input flag_bits, input length_bits,
                  input field_width, input has_precision, input precision,
                  output ready);
endinterface

### hw/rtl/pss_step.sv
// Combinational parse step: one character against the current spec state.
module pss_step import pss_pkg::*; (
  input  logic [CharW-1:0] ch_i,
  input  pss_state_t       st_i,
  output pss_step_t        step_o
);

  logic       cont;
  logic       is_digit;
  pss_state_t nxt;
  pss_rec_t   rec;
  logic       emit;

  assign is_digit = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);

  always_comb begin
    nxt  = st_i;
    emit = 1'b0;
    cont = 1'b1;
    nxt.pending = PEND_NONE;

    // resolve a modifier letter held from the previous beat
    case (st_i.pending)
      PEND_L: begin
        if (ch_i == CH_L) begin
          nxt.length[L_LL] = 1'b1;
          cont = 1'b0;
        end else begin
          nxt.length[L_L] = 1'b1;
        end
      end
      PEND_H: begin
        if (ch_i == CH_H) begin
          nxt.length[L_HH] = 1'b1;
          cont = 1'b0;
        end else begin
          nxt.length[L_H] = 1'b1;
        end
      end
      default: ;
    endcase

    if (cont) begin
      if (is_digit) begin
        if (st_i.in_prec) begin
          nxt.prec = add_digit(st_i.prec, ch_i[3:0]);
        end else if ((ch_i != CH_ZERO) || st_i.in_width) begin
          nxt.width    = add_digit(st_i.width, ch_i[3:0]);
          nxt.in_width = 1'b1;
        end else begin
          nxt.flags[F_ZERO] = 1'b1;
        end
      end else begin
        nxt.in_width = 1'b0;
        nxt.in_prec  = 1'b0;
        case (ch_i)
          CH_MINUS: nxt.flags[F_MINUS] = 1'b1;
          CH_PLUS:  nxt.flags[F_PLUS]  = 1'b1;
          CH_SPACE: nxt.flags[F_SPACE] = 1'b1;
          CH_SHARP: nxt.flags[F_SHARP] = 1'b1;
          CH_DOT: begin
            nxt.dot     = 1'b1;
            nxt.prec    = '0;
            nxt.in_prec = 1'b1;
          end
          CH_Z:     nxt.length[L_Z] = 1'b1;
          CH_J:     nxt.length[L_J] = 1'b1;
          CH_L:     nxt.pending = PEND_L;
          CH_H:     nxt.pending = PEND_H;
          default:  emit = 1'b1;
        endcase
      end
    end

    rec.conv_type     = ch_i;
    rec.flag_bits     = nxt.flags;
    rec.length_bits   = nxt.length;
    rec.field_width   = nxt.width;
    rec.has_precision = nxt.dot;
    rec.precision     = nxt.prec;

    if (emit) begin
      nxt = '0;
    end

    step_o.emit = emit;
    step_o.nxt  = nxt;
    step_o.rec  = rec;
  end

endmodule

### hw/rtl/pss_out_reg.sv
// Result register driving the record channel.
module pss_out_reg import pss_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  pss_rec_t     rec_i,
  output logic         free_o,
  pss_spec_if.source   spec_o
);

  logic     valid_q;
  pss_rec_t rec_q;

  assign free_o = !valid_q || spec_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      rec_q <= rec_i;
    end
  end

  assign spec_o.valid         = valid_q;
  assign spec_o.conv_type     = rec_q.conv_type;
  assign spec_o.flag_bits     = rec_q.flag_bits;
  assign spec_o.length_bits   = rec_q.length_bits;
  assign spec_o.field_width   = rec_q.field_width;
  assign spec_o.has_precision = rec_q.has_precision;
  assign spec_o.precision     = rec_q.precision;

endmodule

### hw/rtl/printf_spec_parser.sv
// printf conversion spec parser: top level.
// Takes one format character per beat (the text after a percent sign) and returns
// one record per conversion: type character, flag bits, length modifier bits,
// saturated width and precision. A character is accepted every cycle unless the
// input stalls; it is held in an input register while the combinational parse step
// updates the spec state, and a terminating character's record is then loaded into
// the result register, which presents it on the record channel.
// Input stalls only when a record is due while the result register is still full.
module printf_spec_parser import pss_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  pss_ch_if.sink     ch_i,
  pss_spec_if.source spec_o
);

  logic             s1_valid_q;
  logic [CharW-1:0] s1_ch_q;
  pss_state_t       state_q;
  pss_step_t        step;
  logic             out_free;
  logic             s1_adv;

  pss_step u_step (
    .ch_i   (s1_ch_q),
    .st_i   (state_q),
    .step_o (step)
  );

  pss_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (s1_adv && step.emit),
    .rec_i  (step.rec),
    .free_o (out_free),
    .spec_o (spec_o)
  );

  assign s1_adv     = s1_valid_q && (!step.emit || out_free);
  assign ch_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      state_q    <= '0;
    end else begin
      if (ch_i.ready) begin
        s1_valid_q <= ch_i.valid;
      end
      if (s1_adv) begin
        state_q <= step.nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ch_i.ready && ch_i.valid) begin
      s1_ch_q <= ch_i.ch;
    end
  end

endmodule

### hw/rtl/pss_checker.sv
// Port-level assertions for the printf spec parser, bound to the top level.
module pss_checker import pss_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [CharW-1:0] conv_type_i,
  input logic             has_precision_i,
  input logic [NumW-1:0]  precision_i
);

  // a stalled record holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(conv_type_i))
    else $error("record dropped or changed while stalled");

  // with the result register empty nothing can block the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

  // precision only accumulates after a dot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !has_precision_i |-> precision_i == '0)
    else $error("precision set without a dot");

  // flags, digits, dots and modifiers never terminate a spec
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !((conv_type_i >= CH_ZERO && conv_type_i <= CH_NINE) ||
                      conv_type_i == CH_MINUS || conv_type_i == CH_PLUS ||
                      conv_type_i == CH_SPACE || conv_type_i == CH_SHARP ||
                      conv_type_i == CH_DOT || conv_type_i == CH_Z ||
                      conv_type_i == CH_J || conv_type_i == CH_L ||
                      conv_type_i == CH_H))
    else $error("record ended on a non-terminating character");

endmodule

bind printf_spec_parser pss_checker u_pss_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (ch_i.ready),
  .out_valid_i     (spec_o.valid),
  .out_ready_i     (spec_o.ready),
  .conv_type_i     (spec_o.conv_type),
  .has_precision_i (spec_o.has_precision),
  .precision_i     (spec_o.precision)
);

### sim/tb_top.sv
// Testbench for printf_spec_parser: directed and random format text against a spec predictor.
module tb_top;
  import pss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandPerPhase = 217;

  typedef struct packed {
    logic [FlagW-1:0] flags;
    logic [LenW-1:0]  lens;
    logic [NumW-1:0]  wid;
    logic             dot;
    logic [NumW-1:0]  prec;
    logic             in_prec;
    logic             in_wid;
    pend_e            pend;
  } spec_acc_t;

  localparam spec_acc_t AccClear = '{flags: '0, lens: '0, wid: '0, dot: 1'b0, prec: '0,
                                     in_prec: 1'b0, in_wid: 1'b0, pend: PEND_NONE};

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             fixed;
    pss_rec_t         spec;
  } stim_row_t;

  // fixed rows carry a record read straight off the spec; the rest use the predictor
  localparam stim_row_t Directed [28] = '{
    '{8'h64, 1'b1, '{8'h64, 5'h00, 6'h00, 16'd0, 1'b0, 16'd0}},
    '{CH_MINUS, 1'b0, '0},
    '{CH_PLUS, 1'b0, '0},
    '{CH_SPACE, 1'b0, '0},
    '{CH_SHARP, 1'b0, '0},
    '{CH_ZERO, 1'b0, '0},
    '{8'h69, 1'b1, '{8'h69, 5'h1f, 6'h00, 16'd0, 1'b0, 16'd0}},
    '{CH_ZERO, 1'b0, '0},
    '{CH_NINE, 1'b0, '0},
    '{CH_NINE, 1'b0, '0},
    '{CH_NINE, 1'b0, '0},
    '{CH_NINE, 1'b0, '0},
    '{CH_NINE, 1'b0, '0},
    '{CH_DOT, 1'b0, '0},
    '{CH_DOT, 1'b0, '0},
    '{8'h37, 1'b0, '0},
    '{CH_ZERO, 1'b0, '0},
    '{8'h46, 1'b0, '0},
    '{CH_H, 1'b0, '0},
    '{CH_H, 1'b0, '0},
    '{CH_J, 1'b0, '0},
    '{CH_Z, 1'b0, '0},
    '{CH_L, 1'b0, '0},
    '{CH_NUL, 1'b1, '{CH_NUL, 5'h00, 6'h36, 16'd0, 1'b0, 16'd0}},
    '{CH_L, 1'b0, '0},
    '{CH_L, 1'b0, '0},
    '{CH_H, 1'b0, '0},
    '{8'hff, 1'b1, '{8'hff, 5'h00, 6'h09, 16'd0, 1'b0, 16'd0}}
  };

  localparam logic [CharW-1:0] FlagChars [5] = '{CH_MINUS, CH_PLUS, CH_SPACE, CH_SHARP, CH_ZERO};
  localparam logic [CharW-1:0] ModChars [4]  = '{CH_H, CH_L, CH_J, CH_Z};

  logic clk_i;
  logic rst_ni;

  pss_ch_if   ch_if ();
  pss_spec_if spec_if ();

  printf_spec_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ch_i   (ch_if),
    .spec_o (spec_if)
  );

  spec_acc_t         acc;
  pss_rec_t          due_specs [$];
  logic [CharW-1:0]  text_q [$];
  int unsigned       src_idle_pct;
  int unsigned       dst_idle_pct;
  int unsigned       mismatches;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [NumW-1:0] decimal_push(logic [NumW-1:0] a, int unsigned d);
    int unsigned v;
    v = a * 10 + d;
    return (v > 65535) ? NumMax : v[NumW-1:0];
  endfunction

  // one character into the spec accumulator; returns 1 when a record is due
  function automatic bit parse_char(input logic [CharW-1:0] c, output pss_rec_t rec);
    pend_e p;
    rec = '0;
    p = acc.pend;
    acc.pend = PEND_NONE;
    if (p == PEND_L) begin
      if (c == CH_L) begin
        acc.lens[L_LL] = 1'b1;
        return 1'b0;
      end
      acc.lens[L_L] = 1'b1;
    end else if (p == PEND_H) begin
      if (c == CH_H) begin
        acc.lens[L_HH] = 1'b1;
        return 1'b0;
      end
      acc.lens[L_H] = 1'b1;
    end
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (acc.in_prec) begin
        acc.prec = decimal_push(acc.prec, c - CH_ZERO);
      end else if (c != CH_ZERO || acc.in_wid) begin
        acc.wid = decimal_push(acc.wid, c - CH_ZERO);
        acc.in_wid = 1'b1;
      end else begin
        acc.flags[F_ZERO] = 1'b1;
      end
      return 1'b0;
    end
    acc.in_wid = 1'b0;
    acc.in_prec = 1'b0;
    case (c)
      CH_MINUS: acc.flags[F_MINUS] = 1'b1;
      CH_PLUS:  acc.flags[F_PLUS] = 1'b1;
      CH_SPACE: acc.flags[F_SPACE] = 1'b1;
      CH_SHARP: acc.flags[F_SHARP] = 1'b1;
      CH_DOT: begin
        acc.dot = 1'b1;
        acc.prec = '0;
        acc.in_prec = 1'b1;
      end
      CH_Z: acc.lens[L_Z] = 1'b1;
      CH_J: acc.lens[L_J] = 1'b1;
      CH_L: acc.pend = PEND_L;
      CH_H: acc.pend = PEND_H;
      default: begin
        rec = '{conv_type: c, flag_bits: acc.flags, length_bits: acc.lens,
                field_width: acc.wid, has_precision: acc.dot, precision: acc.prec};
        acc = AccClear;
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [CharW-1:0] rand_digit(int unsigned lo);
    return CH_ZERO + CharW'($urandom_range(lo, 9));
  endfunction

  // a terminating character: anything that is not a flag, digit, dot or modifier
  function automatic logic [CharW-1:0] rand_conv();
    logic [CharW-1:0] c;
    if ($urandom_range(0, 7) == 0) return CH_NUL;
    do begin
      c = CharW'($urandom_range(0, 255));
    end while (c inside {[CH_ZERO:CH_NINE], CH_MINUS, CH_PLUS, CH_SPACE, CH_SHARP, CH_DOT,
                         CH_Z, CH_J, CH_L, CH_H});
    return c;
  endfunction

  task automatic compose_spec();
    int unsigned mode;
    int unsigned n;
    mode = $urandom_range(0, 9);
    if (mode >= 8) begin
      repeat ($urandom_range(1, 4)) text_q.push_back(CharW'($urandom_range(0, 255)));
    end else if (mode == 7) begin
      // spec pieces in scrambled order, left for the next record to absorb
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(0, 3))
          0:       text_q.push_back(FlagChars[$urandom_range(0, 4)]);
          1:       text_q.push_back(rand_digit(0));
          2:       text_q.push_back(CH_DOT);
          default: text_q.push_back(ModChars[$urandom_range(0, 3)]);
        endcase
      end
    end else begin
      repeat ($urandom_range(0, 3)) text_q.push_back(FlagChars[$urandom_range(0, 4)]);
      if ($urandom_range(0, 1) == 1) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
        text_q.push_back(rand_digit(1));
        repeat (n - 1) text_q.push_back(rand_digit(0));
      end
      if ($urandom_range(0, 1) == 1) begin
        repeat ($urandom_range(1, 2)) begin
          text_q.push_back(CH_DOT);
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 3);
          repeat (n) text_q.push_back(rand_digit(0));
        end
      end
      case ($urandom_range(0, 7))
        0: text_q.push_back(CH_H);
        1: begin
          text_q.push_back(CH_H);
          text_q.push_back(CH_H);
        end
        2: text_q.push_back(CH_L);
        3: begin
          text_q.push_back(CH_L);
          text_q.push_back(CH_L);
        end
        4: text_q.push_back(CH_J);
        5: text_q.push_back(CH_Z);
        6: begin
          text_q.push_back(ModChars[$urandom_range(0, 3)]);
          text_q.push_back(ModChars[$urandom_range(0, 3)]);
        end
        default: ;
      endcase
      text_q.push_back(rand_conv());
    end
  endtask

  // called and returns at a falling edge; valid stays high into the next call
  task automatic send_char(input logic [CharW-1:0] c, input bit fixed, input pss_rec_t fixed_spec);
    pss_rec_t spec;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      ch_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    ch_if.valid <= 1'b1;
    ch_if.ch    <= c;
    @(posedge clk_i);
    while (!ch_if.ready) @(posedge clk_i);
    if (parse_char(c, spec)) due_specs.push_back(fixed ? fixed_spec : spec);
    @(negedge clk_i);
  endtask

  task automatic drain_specs();
    ch_if.valid <= 1'b0;
    while (due_specs.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    spec_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      spec_if.ready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    pss_rec_t want;
    if (rst_ni && spec_if.valid && spec_if.ready) begin
      if (due_specs.size() == 0) begin
        $display("%0t ns: unexpected record, type 0x%0h", $time, spec_if.conv_type);
        mismatches++;
      end else begin
        want = due_specs.pop_front();
        check_field("conv_type", want.conv_type, spec_if.conv_type);
        check_field("flag_bits", want.flag_bits, spec_if.flag_bits);
        check_field("length_bits", want.length_bits, spec_if.length_bits);
        check_field("field_width", want.field_width, spec_if.field_width);
        check_field("has_precision", want.has_precision, spec_if.has_precision);
        check_field("precision", want.precision, spec_if.precision);
      end
    end
  end

  initial begin
    int unsigned n_rand;
    rst_ni       = 1'b0;
    ch_if.valid  = 1'b0;
    ch_if.ch     = '0;
    src_idle_pct = 29;
    dst_idle_pct = 87;
    mismatches   = 0;
    n_rand       = 0;
    acc          = AccClear;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (Directed[i]) send_char(Directed[i].ch, Directed[i].fixed, Directed[i].spec);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        1: begin
          src_idle_pct = 87;
          dst_idle_pct = 29;
        end
        2: begin
          src_idle_pct = 0;
          dst_idle_pct = 0;
        end
        default: ;
      endcase
      while (n_rand < (ph + 1) * RandPerPhase) begin
        compose_spec();
        while (text_q.size() != 0) begin
          send_char(text_q.pop_front(), 1'b0, '0);
          n_rand++;
        end
      end
      // hold the input off until every record of this phase is out
      drain_specs();
    end

    repeat (10) @(posedge clk_i);
    if (due_specs.size() != 0) begin
      $display("%0t ns: %0d records never arrived", $time, due_specs.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("[printf_spec_parser] OK");
    end else begin
      $display("[printf_spec_parser] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t ns: timeout, %0d records outstanding", $time, due_specs.size());
    $display("[printf_spec_parser] ERROR");
    $finish;
  end

endmodule

### files.f
hw/rtl/pss_pkg.sv
hw/rtl/pss_if.sv
hw/rtl/pss_step.sv
hw/rtl/pss_out_reg.sv
hw/rtl/printf_spec_parser.sv
hw/rtl/pss_checker.sv
sim/tb_top.sv
